// File: design/bhq_pkg.sv
`default_nettype none
package bhq_pkg;
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;
  localparam int OUT_KEY_W = 16;
  localparam int OUT_TAG_W = 16;
  localparam int COUNT_W   = 9;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input word
    logic rd;        // issue read(s) for current step
    logic step;      // evaluate read data, move entry or finish
    logic pop_start; // remove: rearm the pop before the last-entry read
    logic finish;    // publish result
  } bhq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;      // sift terminated
    logic err;       // empty or full
  } bhq_sts_t;
endpackage
`default_nettype wire

// File: design/bhq_if.sv
`default_nettype none
interface bhq_in_if #(parameter int KEY_WIDTH = 16, parameter int TAG_WIDTH = 16);
  logic valid;
  logic ready;
  logic action;
  logic [KEY_WIDTH-1:0] key;
  logic [TAG_WIDTH-1:0] tag;
  modport source (output valid, action, key, tag, input ready);
  modport sink (input valid, action, key, tag, output ready);
endinterface

interface bhq_out_if;
  logic valid;
  logic ready;
  logic [15:0] top_key;
  logic [15:0] top_tag;
  logic [1:0] status;
  logic [8:0] count_after;
  modport source (output valid, top_key, top_tag, status, count_after, input ready);
  modport sink (input valid, top_key, top_tag, status, count_after, output ready);
endinterface
`default_nettype wire

// File: design/bhq_ctrl.sv
`default_nettype none
module bhq_ctrl
  import bhq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     in_action,
  output logic          out_valid,
  input  wire logic     out_ready,
  output bhq_cmd_t      cmd,
  input  wire bhq_sts_t sts
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CHK  = 6'b000010,
    S_POP  = 6'b000100,
    S_RD   = 6'b001000,
    S_EVAL = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   is_remove;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      is_remove <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) is_remove <= in_action;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // sequencer: one memory read then one evaluate per heap level
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.err) begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end else if (is_remove) begin
          cmd.pop_start = 1'b1;
          state_next = S_POP;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_POP: begin
        cmd.rd = 1'b1;
        state_next = S_EVAL;
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.step = 1'b1;
        if (sts.done) begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end else begin
          state_next = S_RD;
        end
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: design/bhq_dp.sv
`default_nettype none
module bhq_dp
  import bhq_pkg::*;
#(
  parameter int HEAP_DEPTH = 256,
  parameter int KEY_WIDTH  = 16,
  parameter int TAG_WIDTH  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_action,
  input  wire logic [KEY_WIDTH-1:0] in_key,
  input  wire logic [TAG_WIDTH-1:0] in_tag,
  input  wire bhq_cmd_t             cmd,
  output bhq_sts_t                  sts,
  output logic [OUT_KEY_W-1:0]      top_key,
  output logic [OUT_TAG_W-1:0]      top_tag,
  output logic [1:0]                status,
  output logic [COUNT_W-1:0]        count_after
);
  localparam int AW = $clog2(HEAP_DEPTH + 1);   // position width, 1-based
  localparam int EW = KEY_WIDTH + TAG_WIDTH;
  localparam logic [AW-1:0] DEPTH = AW'(HEAP_DEPTH);
  localparam logic [AW-1:0] ONE = AW'(1);

  // entry memory, two read ports (children, or parent, or last entry and root), one write port
  logic [EW-1:0] mem [1:HEAP_DEPTH];
  logic [EW-1:0] rd_a, rd_b;
  logic [AW-1:0] ra_a, ra_b, wa;
  logic [EW-1:0] wd;
  logic          we;

  logic [AW-1:0]        count, n, pos;
  logic                 act, popped;
  logic [KEY_WIDTH-1:0] mk;
  logic [TAG_WIDTH-1:0] mt;
  logic [EW-1:0]        root;

  logic [KEY_WIDTH-1:0] ka, kb;
  logic                 has_b, pick_b, stop;
  logic [AW-1:0]        child;
  logic [AW:0]          dbl;

  function automatic logic in_action_q_err(input logic a, input logic [AW-1:0] c);
    return (a == ACT_INSERT) ? (c == DEPTH) : (c == '0);
  endfunction
  function automatic logic popped_or_ins(input logic a, input logic p);
    return (a == ACT_INSERT) || p;
  endfunction

  assign ka = rd_a[EW-1:TAG_WIDTH];
  assign kb = rd_b[EW-1:TAG_WIDTH];
  assign dbl = {pos, 1'b0};

  // read addresses: up = parent, pop = last entry and root, down = both children
  always_comb begin
    if (act == ACT_INSERT) begin
      ra_a = pos >> 1;
      ra_b = pos >> 1;
    end else if (!popped) begin
      ra_a = n + ONE;     // last entry before the pop
      ra_b = ONE;         // root
    end else begin
      ra_a = dbl[AW-1:0];
      ra_b = dbl[AW-1:0] + ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_a <= mem[ra_a];
      rd_b <= mem[ra_b];
    end
    if (we) mem[wa] <= wd;
  end

  // one level of the sift
  always_comb begin
    has_b  = (dbl < {1'b0, n});
    pick_b = has_b && (ka < kb);
    child  = pick_b ? dbl[AW-1:0] + ONE : dbl[AW-1:0];
    if (act == ACT_INSERT)
      stop = (pos == ONE) || (ka > mk);
    else if (!popped)
      stop = 1'b0;
    else
      stop = (dbl > {1'b0, n}) || (mk >= (pick_b ? kb : ka));
    we = 1'b0; wa = pos; wd = {mk, mt};
    if (cmd.step && popped || cmd.step && act == ACT_INSERT) begin
      we = 1'b1;
      if (stop) wd = {mk, mt};
      else wd = (pick_b && act != ACT_INSERT) ? rd_b : rd_a;
    end
    sts.err  = (in_action_q_err(act, count));
    sts.done = stop && popped_or_ins(act, popped);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.finish && !sts.err) begin
      count <= (act == ACT_INSERT) ? count + ONE : count - ONE;
    end
    if (cmd.load) begin
      act <= in_action;
      mk  <= in_key;
      mt  <= in_tag;
      popped <= 1'b0;
      if (in_action == ACT_INSERT) begin
        pos <= count + ONE;
        n   <= count + ONE;
      end else begin
        pos <= ONE;
        n   <= count - ONE;
      end
    end
    if (cmd.pop_start) popped <= 1'b0;
    if (cmd.step) begin
      if (act != ACT_INSERT && !popped) begin
        // capture root, take last entry as the moving one
        root   <= rd_b;
        mk     <= rd_a[EW-1:TAG_WIDTH];
        mt     <= rd_a[TAG_WIDTH-1:0];
        popped <= 1'b1;
      end else if (!stop) begin
        pos <= (act == ACT_INSERT) ? pos >> 1 : child;
      end
    end
    if (cmd.finish) begin
      if (sts.err) begin
        status <= (act == ACT_INSERT) ? ST_FULL : ST_EMPTY;
        top_key <= '0;
        top_tag <= '0;
        count_after <= COUNT_W'(count);
      end else begin
        status <= ST_DONE;
        if (act == ACT_INSERT) begin
          top_key <= '0;
          top_tag <= '0;
          count_after <= COUNT_W'(count + ONE);
        end else begin
          top_key <= OUT_KEY_W'(root[EW-1:TAG_WIDTH]);
          top_tag <= OUT_TAG_W'(root[TAG_WIDTH-1:0]);
          count_after <= COUNT_W'(count - ONE);
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: design/binary_max_heap_queue.sv
`default_nettype none
// Binary max-heap priority queue of HEAP_DEPTH key/tag entries. Each input
// word inserts or removes the top entry; exactly one result word follows.
// An insert steps through accept, check, then a read and a compare/write per
// heap level it compares, the first read issued in the check state, then the
// result state. A remove steps through accept, check, pop read, pop capture,
// a read and a compare/write per level, and result. One operation runs at a
// time.
module binary_max_heap_queue
  import bhq_pkg::*;
#(
  parameter int HEAP_DEPTH = 256,
  parameter int KEY_WIDTH  = 16,
  parameter int TAG_WIDTH  = 16
) (
  input wire logic clk,
  input wire logic rst,
  bhq_in_if.sink   in_ch,
  bhq_out_if.source out_ch
);
  bhq_cmd_t cmd;
  bhq_sts_t sts;

  bhq_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_action(in_ch.action),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  bhq_dp #(.HEAP_DEPTH(HEAP_DEPTH), .KEY_WIDTH(KEY_WIDTH), .TAG_WIDTH(TAG_WIDTH)) u_dp (
    .clk, .rst,
    .in_action(in_ch.action), .in_key(in_ch.key), .in_tag(in_ch.tag),
    .cmd, .sts,
    .top_key(out_ch.top_key), .top_tag(out_ch.top_tag),
    .status(out_ch.status), .count_after(out_ch.count_after)
  );

`ifndef SYNTHESIS
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.status != 2'd3) else $error("bad status");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != ST_DONE) |-> out_ch.top_key == '0)
    else $error("error result carries key");
`endif
endmodule
`default_nettype wire

// File: tb/heap_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module heap_checker
  import bhq_pkg::*;
#(
  parameter int HEAP_DEPTH = 256
) (
  input wire logic clk,
  input wire logic rst,
  bhq_in_if.sink   in_mon,
  bhq_out_if.sink  out_mon,
  output int       fail_count,
  output int       pending_count,
  output int       remove_count,
  output int       full_count,
  output int       empty_count
);
  typedef struct packed {
    logic [15:0] top_key;
    logic [15:0] top_tag;
    logic [1:0]  status;
    logic [8:0]  count_after;
  } heap_result_t;

  // shadow heap, positions 1..heap_size
  logic [15:0]  shadow_key [1:HEAP_DEPTH];
  logic [15:0]  shadow_tag [1:HEAP_DEPTH];
  int           heap_size;
  heap_result_t result_fifo [$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic heap_result_t apply_word(input logic act, input logic [15:0] k,
                                              input logic [15:0] t);
    heap_result_t r;
    int pos;
    int c;
    logic [15:0] mk;
    logic [15:0] mt;
    r = '0;
    r.status = ST_DONE;
    if (act == ACT_INSERT) begin
      if (heap_size >= HEAP_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        heap_size++;
        pos = heap_size;
        // parents with key <= new key move down
        while (pos > 1 && shadow_key[pos/2] <= k) begin
          shadow_key[pos] = shadow_key[pos/2];
          shadow_tag[pos] = shadow_tag[pos/2];
          pos = pos / 2;
        end
        shadow_key[pos] = k;
        shadow_tag[pos] = t;
      end
    end else if (heap_size == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.top_key = shadow_key[1];
      r.top_tag = shadow_tag[1];
      mk = shadow_key[heap_size];
      mt = shadow_tag[heap_size];
      heap_size--;
      pos = 1;
      // follow larger child, left on tie
      while (pos <= heap_size / 2) begin
        c = 2 * pos;
        if (c < heap_size && shadow_key[c] < shadow_key[c+1]) c++;
        if (mk >= shadow_key[c]) break;
        shadow_key[pos] = shadow_key[c];
        shadow_tag[pos] = shadow_tag[c];
        pos = c;
      end
      if (heap_size > 0) begin
        shadow_key[pos] = mk;
        shadow_tag[pos] = mt;
      end
    end
    r.count_after = heap_size[8:0];
    return r;
  endfunction

  assign pending_count = result_fifo.size();

  always @(posedge clk) begin
    heap_result_t want;
    if (rst) begin
      heap_size    = 0;
      fail_count   = 0;
      remove_count = 0;
      full_count   = 0;
      empty_count  = 0;
      result_fifo.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        want = apply_word(in_mon.action, in_mon.key, in_mon.tag);
        result_fifo.push_back(want);
        if (want.status == ST_FULL) full_count++;
        else if (want.status == ST_EMPTY) empty_count++;
        else if (in_mon.action == ACT_REMOVE) remove_count++;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (result_fifo.size() == 0) begin
          report("unexpected word", 32'd0, 32'd0);
        end else begin
          want = result_fifo.pop_front();
          if (out_mon.top_key !== want.top_key)
            report("top_key", 32'(out_mon.top_key), 32'(want.top_key));
          if (out_mon.top_tag !== want.top_tag)
            report("top_tag", 32'(out_mon.top_tag), 32'(want.top_tag));
          if (out_mon.status !== want.status)
            report("status", 32'(out_mon.status), 32'(want.status));
          if (out_mon.count_after !== want.count_after)
            report("count_after", 32'(out_mon.count_after), 32'(want.count_after));
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import bhq_pkg::*;

  localparam int DEPTH = 256;
  localparam int IDLE_LIMIT = 4000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   remove_count;
  int   full_count;
  int   empty_count;
  int   idle_cycles;
  int   word_count;

  bhq_in_if  in_ch ();
  bhq_out_if out_ch ();

  binary_max_heap_queue #(.HEAP_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  heap_checker #(.HEAP_DEPTH(DEPTH)) i_checker (
    .clk(clk), .rst(rst), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .fail_count(fail_count), .pending_count(pending_count),
    .remove_count(remove_count), .full_count(full_count), .empty_count(empty_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired");
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stall per word
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      repeat (gap) @(posedge clk);
      out_ch.ready <= 1'b1;
      @(posedge clk iff out_ch.valid);
      out_ch.ready <= 1'b0;
    end
  end

  task automatic send_word(input logic act, input logic [15:0] k, input logic [15:0] t,
                           input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.key    <= k;
    in_ch.tag    <= t;
    @(posedge clk iff in_ch.ready);
    word_count++;
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
  endfunction

  initial begin
    int n;
    int fill;
    logic [15:0] k;
    rst = 1'b1;
    word_count = 0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_INSERT;
    in_ch.key = '0;
    in_ch.tag = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty remove, extremes, equal keys
    send_word(ACT_REMOVE, 16'h0, 16'h0, 0);
    send_word(ACT_INSERT, 16'hFFFF, 16'hFFFF, 0);
    send_word(ACT_INSERT, 16'h0000, 16'h0000, 0);
    send_word(ACT_INSERT, 16'h8000, 16'h1234, 0);
    send_word(ACT_INSERT, 16'h8000, 16'h5678, 0);
    send_word(ACT_INSERT, 16'h8000, 16'h9ABC, 1);
    send_word(ACT_INSERT, 16'h7FFF, 16'hAAAA, 0);
    send_word(ACT_INSERT, 16'h0001, 16'h5555, 2);
    repeat (8) send_word(ACT_REMOVE, 16'h0, 16'h0, 0);

    // fill to capacity, then overflow, then drain past empty
    for (int i = 0; i < DEPTH; i++)
      send_word(ACT_INSERT, $urandom_range(0, 3) == 0 ? 16'h4444 : 16'($urandom),
                16'($urandom), draw_gap());
    send_word(ACT_INSERT, 16'hFFFF, 16'hFFFF, 0);
    send_word(ACT_INSERT, 16'h0000, 16'h0000, 3);
    // hold off until all results are back
    in_ch.valid <= 1'b0;
    @(posedge clk iff pending_count == 0);
    for (int i = 0; i < DEPTH + 1; i++) send_word(ACT_REMOVE, 16'h0, 16'h0, draw_gap());

    // random: bursts of inserts and removes with biased key ranges
    n = 0;
    while (n < 370) begin
      fill = $urandom_range(1, 12);
      for (int j = 0; j < fill; j++) begin
        case ($urandom_range(0, 2))
          0: k = 16'($urandom_range(0, 7));
          1: k = 16'($urandom);
          default: k = 16'hFFF0 | 16'($urandom_range(0, 15));
        endcase
        send_word(($urandom_range(0, 9) < 6) ? ACT_INSERT : ACT_REMOVE, k,
                  16'($urandom), draw_gap());
        n++;
      end
      for (int j = 0; j < $urandom_range(0, 8); j++) begin
        send_word(ACT_REMOVE, 16'($urandom), 16'($urandom), draw_gap());
        n++;
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk iff pending_count == 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d words: %0d removes returned data, %0d empty removes, %0d full inserts",
             word_count, remove_count, empty_count, full_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
